[rtl/ctd_pkg.sv]
`default_nettype none

package ctd_pkg;

   localparam int SMOOTHING_PCT    = 20;
   localparam int TAPER_MARGIN_PCT = 100;
   localparam int TAPER_MIN_PCT    = 5;
   localparam int TAPER_MAX_PCT    = 50;
   localparam int IMPLAUSIBLE_MA   = 30000;

   localparam logic [6:0] RATIO_DEFAULT = 7'd20;

   localparam int MA_W    = 15;
   localparam int TIME_W  = 32;
   localparam int RAW_W   = 16;
   localparam int PCT_W   = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // x / 100 by reciprocal, exact for x below 2^22
   localparam int          DIV_IN_W  = 22;
   localparam int          DIV_SHIFT = 32;
   localparam logic [25:0] DIV100_MUL = 26'd42949673;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAPER_RATIO   = 4'd0,
      CSR_OVERCURRENT   = 4'd1,
      CSR_UNPLUG        = 4'd2,
      CSR_UNPLUG_CONF   = 4'd3,
      CSR_TAPER_CONF    = 4'd4,
      CSR_MIN_CHARGE    = 4'd5,
      CSR_MIN_PEAK      = 4'd6,
      CSR_TAPER_FLOOR   = 4'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      OUTCOME_CHARGE  = 2'd0,
      OUTCOME_OVERCUR = 2'd1,
      OUTCOME_DETACH  = 2'd2,
      OUTCOME_DONE    = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      KIND_SESSION,
      KIND_IMPLAUSIBLE,
      KIND_SAMPLE
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [TIME_W-1:0]   now_ms;
      logic [MA_W-1:0]     raw_ma;   // clamped at zero
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   function automatic logic [15:0] div100(input logic [DIV_IN_W-1:0] x);
      logic [DIV_IN_W+25:0] p;
      p = {26'd0, x} * {{DIV_IN_W{1'b0}}, DIV100_MUL};
      return p[DIV_SHIFT+15:DIV_SHIFT];
   endfunction

   // effective taper percent from the clamped session ratio
   function automatic logic [PCT_W-1:0] eff_pct(input logic [PCT_W-1:0] ratio);
      logic [DIV_IN_W-1:0] prod;
      logic [15:0]         e;
      prod = DIV_IN_W'(ratio) * DIV_IN_W'(TAPER_MARGIN_PCT);
      e    = div100(prod);
      if (e > 16'(TAPER_MAX_PCT)) begin
         e = 16'(TAPER_MAX_PCT);
      end else if (e < 16'(TAPER_MIN_PCT)) begin
         e = 16'(TAPER_MIN_PCT);
      end
      return e[PCT_W-1:0];
   endfunction

   function automatic logic [PCT_W-1:0] clamp_ratio(input logic [PCT_W-1:0] r);
      logic [PCT_W-1:0] c;
      c = r;
      if (r < PCT_W'(TAPER_MIN_PCT)) begin
         c = PCT_W'(TAPER_MIN_PCT);
      end else if (r > PCT_W'(TAPER_MAX_PCT)) begin
         c = PCT_W'(TAPER_MAX_PCT);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/ctd_front.sv]
`default_nettype none

module ctd_front
   import ctd_pkg::*;
(
   input  wire logic                    req_valid,
   input  wire logic                    req_action,
   input  wire logic [TIME_W-1:0]       req_now_ms,
   input  wire logic signed [RAW_W-1:0] req_raw_ma,
   input  wire logic                    queue_full,
   output logic                         req_stall,
   output logic                         push,
   output item_type                     push_item
);

   localparam logic signed [RAW_W-1:0] IMPL_HI = RAW_W'(IMPLAUSIBLE_MA);
   localparam logic signed [RAW_W-1:0] IMPL_LO = -RAW_W'(IMPLAUSIBLE_MA);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.now_ms = req_now_ms;
      push_item.raw_ma = req_raw_ma[RAW_W-1] ? '0 : req_raw_ma[MA_W-1:0];
      if (req_action) begin
         push_item.kind = KIND_SESSION;
      end else if (req_raw_ma > IMPL_HI || req_raw_ma < IMPL_LO) begin
         push_item.kind = KIND_IMPLAUSIBLE;
      end else begin
         push_item.kind = KIND_SAMPLE;
      end
   end

endmodule

`default_nettype wire

[rtl/ctd_queue.sv]
`default_nettype none

module ctd_queue
   import ctd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output logic          full,
   output queue_head_type head
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full = count_ff[1];
   assign head = {count_ff != 2'd0, slot_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[rtl/ctd_back.sv]
`default_nettype none

module ctd_back
   import ctd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire queue_head_type        head,
   output logic                       pop,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_verdict,
   output logic [MA_W-1:0]            rsp_smoothed_ma,
   output logic [MA_W-1:0]            rsp_peak_ma,
   output logic [MA_W-1:0]            rsp_cutoff_ma
);

   // configuration
   logic [PCT_W-1:0]  cfg_ratio_ff;
   logic [MA_W-1:0]   cfg_over_ff, cfg_unplug_ff, cfg_min_peak_ff, cfg_floor_ff;
   logic [TIME_W-1:0] cfg_unplug_conf_ff, cfg_taper_conf_ff, cfg_min_charge_ff;

   // session state
   logic [PCT_W-1:0]  eff_ff,          eff_in;
   logic [TIME_W-1:0] session_ff,      session_in;
   logic [TIME_W-1:0] below_since_ff,  below_since_in;
   logic [TIME_W-1:0] unplug_since_ff, unplug_since_in;
   logic [MA_W-1:0]   smoothed_ff,     smoothed_in;
   logic [MA_W-1:0]   peak_ff,         peak_in;
   logic [MA_W-1:0]   cutoff_ff,       cutoff_in;
   logic              below_ff,        below_in;
   logic              unplug_ff,       unplug_in;
   logic              primed_ff,       primed_in;

   logic              rsp_valid_ff,    rsp_valid_in;
   verdict_type       verdict_ff,      verdict_in;
   logic [MA_W-1:0]   out_sm_ff,       out_sm_in;
   logic [MA_W-1:0]   out_peak_ff,     out_peak_in;
   logic [MA_W-1:0]   out_cut_ff,      out_cut_in;

   logic                    step;
   logic signed [MA_W:0]    diff;
   logic [MA_W-1:0]         mag;
   logic [DIV_IN_W-1:0]     sm_prod, thr_prod;
   logic [15:0]             sm_q, thr_q;
   logic [MA_W-1:0]         sm_new, peak_new, thr_old, thr_eff;
   logic                    below_now, done;
   logic [TIME_W-1:0]       bs_new;

   assign step = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = step;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_smoothed_ma = out_sm_ff;
   assign rsp_peak_ma     = out_peak_ff;
   assign rsp_cutoff_ma   = out_cut_ff;

   // filter step and the old-peak threshold run side by side
   always_comb begin
      diff    = $signed({1'b0, head.item.raw_ma}) - $signed({1'b0, smoothed_ff});
      mag     = diff[MA_W] ? MA_W'(-diff) : diff[MA_W-1:0];
      sm_prod = DIV_IN_W'(mag) * DIV_IN_W'(SMOOTHING_PCT);
      sm_q    = div100(sm_prod);
      if (!primed_ff) begin
         sm_new = head.item.raw_ma;
      end else if (diff[MA_W]) begin
         sm_new = smoothed_ff - sm_q[MA_W-1:0];
      end else begin
         sm_new = smoothed_ff + sm_q[MA_W-1:0];
      end
      thr_prod = DIV_IN_W'(peak_ff) * DIV_IN_W'(eff_ff);
      thr_q    = div100(thr_prod);
      thr_old  = thr_q[MA_W-1:0];
      thr_eff  = (thr_old > cfg_floor_ff) ? thr_old : cfg_floor_ff;
   end

   always_comb begin
      eff_in          = eff_ff;
      session_in      = session_ff;
      below_since_in  = below_since_ff;
      unplug_since_in = unplug_since_ff;
      smoothed_in     = smoothed_ff;
      peak_in         = peak_ff;
      cutoff_in       = cutoff_ff;
      below_in        = below_ff;
      unplug_in       = unplug_ff;
      primed_in       = primed_ff;
      verdict_in      = OUTCOME_CHARGE;
      peak_new        = (sm_new > peak_ff) ? sm_new : peak_ff;
      below_now       = 1'b0;
      done            = 1'b0;
      bs_new          = below_since_ff;

      case (head.item.kind)
         KIND_SESSION: begin
            eff_in          = eff_pct(clamp_ratio(cfg_ratio_ff));
            session_in      = head.item.now_ms;
            below_since_in  = head.item.now_ms;
            unplug_since_in = head.item.now_ms;
            smoothed_in     = '0;
            peak_in         = '0;
            cutoff_in       = '0;
            below_in        = 1'b0;
            unplug_in       = 1'b0;
            primed_in       = 1'b0;
         end
         KIND_SAMPLE: begin
            smoothed_in = sm_new;
            primed_in   = 1'b1;
            if (sm_new > cfg_over_ff) begin
               verdict_in = OUTCOME_OVERCUR;
            end else begin
               peak_in = peak_new;
               if (sm_new < cfg_unplug_ff) begin
                  if (!unplug_ff) begin
                     unplug_in       = 1'b1;
                     unplug_since_in = head.item.now_ms;
                  end else if (head.item.now_ms - unplug_since_ff >= cfg_unplug_conf_ff) begin
                     verdict_in = OUTCOME_DETACH;
                     done       = 1'b1;
                  end
               end else begin
                  unplug_in = 1'b0;
               end
               if (!done) begin
                  // a new peak is always at or above its own fraction
                  below_now = (sm_new > peak_ff) ? (sm_new < cfg_floor_ff)
                                                 : (sm_new < thr_eff);
                  if (below_now) begin
                     below_in = 1'b1;
                     if (!below_ff) begin
                        bs_new = head.item.now_ms;
                     end
                  end else begin
                     below_in = 1'b0;
                  end
                  below_since_in = bs_new;
                  if (head.item.now_ms - session_ff >= cfg_min_charge_ff) begin
                     if (peak_new < cfg_min_peak_ff) begin
                        cutoff_in  = sm_new;
                        verdict_in = OUTCOME_DONE;
                     end else if (below_in &&
                                  head.item.now_ms - bs_new >= cfg_taper_conf_ff) begin
                        cutoff_in  = sm_new;
                        verdict_in = OUTCOME_DONE;
                     end
                  end
               end
            end
         end
         default: begin
            verdict_in = OUTCOME_OVERCUR;
         end
      endcase

      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && rsp_stall);
      out_sm_in    = smoothed_in;
      out_peak_in  = peak_in;
      out_cut_in   = cutoff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ratio_ff       <= RATIO_DEFAULT;
         cfg_over_ff        <= MA_W'(16000);
         cfg_unplug_ff      <= MA_W'(20);
         cfg_unplug_conf_ff <= TIME_W'(5000);
         cfg_taper_conf_ff  <= TIME_W'(60000);
         cfg_min_charge_ff  <= TIME_W'(120000);
         cfg_min_peak_ff    <= MA_W'(100);
         cfg_floor_ff       <= MA_W'(50);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TAPER_RATIO: cfg_ratio_ff       <= csr_data[PCT_W-1:0];
            CSR_OVERCURRENT: cfg_over_ff        <= csr_data[MA_W-1:0];
            CSR_UNPLUG:      cfg_unplug_ff      <= csr_data[MA_W-1:0];
            CSR_UNPLUG_CONF: cfg_unplug_conf_ff <= csr_data;
            CSR_TAPER_CONF:  cfg_taper_conf_ff  <= csr_data;
            CSR_MIN_CHARGE:  cfg_min_charge_ff  <= csr_data;
            CSR_MIN_PEAK:    cfg_min_peak_ff    <= csr_data[MA_W-1:0];
            CSR_TAPER_FLOOR: cfg_floor_ff       <= csr_data[MA_W-1:0];
            default: ;
         endcase
      end

      if (reset) begin
         eff_ff          <= eff_pct(RATIO_DEFAULT);
         session_ff      <= '0;
         below_since_ff  <= '0;
         unplug_since_ff <= '0;
         smoothed_ff     <= '0;
         peak_ff         <= '0;
         cutoff_ff       <= '0;
         below_ff        <= 1'b0;
         unplug_ff       <= 1'b0;
         primed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            eff_ff          <= eff_in;
            session_ff      <= session_in;
            below_since_ff  <= below_since_in;
            unplug_since_ff <= unplug_since_in;
            smoothed_ff     <= smoothed_in;
            peak_ff         <= peak_in;
            cutoff_ff       <= cutoff_in;
            below_ff        <= below_in;
            unplug_ff       <= unplug_in;
            primed_ff       <= primed_in;
         end
      end

      if (step) begin
         verdict_ff  <= verdict_in;
         out_sm_ff   <= out_sm_in;
         out_peak_ff <= out_peak_in;
         out_cut_ff  <= out_cut_in;
      end
   end

   a_session_clears: assert property (@(posedge clock) disable iff (reset)
      step && head.item.kind == KIND_SESSION |=>
         smoothed_ff == '0 && peak_ff == '0 && cutoff_ff == '0 && !primed_ff)
      else $error("session start did not clear filter state");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      step && head.item.kind != KIND_SESSION |=> peak_ff >= $past(peak_ff))
      else $error("peak dropped within a session");

   a_full_cutoff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && verdict_ff == OUTCOME_DONE |-> out_cut_ff == out_sm_ff)
      else $error("full verdict without matching cutoff");

   a_no_step_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !pop)
      else $error("queue popped while result beat is stalled");

endmodule

`default_nettype wire

[rtl/charge_taper_detector.sv]
// Charge taper detector.
// Request channel (req_valid/req_stall): one beat per item, req_action = 1
// starts a session, otherwise req_raw_ma is a current sample at req_now_ms.
// Response channel (rsp_valid/rsp_stall): exactly one beat per request, in
// order, carrying verdict, smoothed, peak and cutoff currents.
// CSR channel (csr_valid/csr_ready): csr_ready is always high; csr_index picks
// the register, indexes above 7 are dropped. Write only while idle.
// An accepted request is written to the queue, and the back end then registers
// its response. Throughput: one item per cycle unless rsp_stall holds a
// response, set by the back end state update (filter step plus peak, unplug and taper checks).
// A two-beat queue sits between the classifier and the back end, so requests
// keep flowing while a response waits; req_stall rises only when the queue is
// full, which happens after two beats pile up behind a stalled response.
// Reset (synchronous, active high) loads register defaults, clears session
// state and empties the queue; no request is lost across a rsp_stall.
`default_nettype none

module charge_taper_detector
   import ctd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_action,
   input  wire logic [TIME_W-1:0]       req_now_ms,
   input  wire logic signed [RAW_W-1:0] req_raw_ma,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_verdict,
   output logic [MA_W-1:0]              rsp_smoothed_ma,
   output logic [MA_W-1:0]              rsp_peak_ma,
   output logic [MA_W-1:0]              rsp_cutoff_ma,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   logic           push, pop, queue_full;
   item_type       push_item;
   queue_head_type head;

   assign csr_ready = 1'b1;

   ctd_front u_front (
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_now_ms (req_now_ms),
      .req_raw_ma (req_raw_ma),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_item  (push_item)
   );

   ctd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   ctd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .head            (head),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_verdict     (rsp_verdict),
      .rsp_smoothed_ma (rsp_smoothed_ma),
      .rsp_peak_ma     (rsp_peak_ma),
      .rsp_cutoff_ma   (rsp_cutoff_ma)
   );

endmodule

`default_nettype wire
